[src/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  typedef logic [15:0] cell_t;
  typedef logic [2:0]  opcode_t;
  typedef logic [1:0]  cfg_index_t;

  localparam opcode_t OP_PUT   = 3'd0;
  localparam opcode_t OP_WRITE = 3'd1;
  localparam opcode_t OP_READ  = 3'd2;
  localparam opcode_t OP_SET   = 3'd3;
  localparam opcode_t OP_CLEAR = 3'd4;

  localparam cfg_index_t CFG_FG    = 2'd0;
  localparam cfg_index_t CFG_BG    = 2'd1;
  localparam cfg_index_t CFG_BLINK = 2'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned TAB_STOP = 4;
  localparam int unsigned TAB_BITS = 3;

  localparam int unsigned COL_BITS = 7;
  localparam int unsigned ROW_BITS = 5;
  localparam int unsigned POS_BITS = 11;

  localparam cell_t      CELL_RESET = 16'h0720;
  localparam logic [3:0] FG_RESET   = 4'd7;

  // background and blink are ORed into the top nibble
  function automatic cell_t make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                                      logic blink);
    return {bg | {blink, 3'b000}, fg, ch};
  endfunction

endpackage

`default_nettype wire

[src/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/text_console_writer_top.sv]
`default_nettype none

// channel   signals                                   handshake
// command   opcode data_byte column_in row_in         start & !busy
// result    read_entry cursor_column cursor_row       done, one cycle, no stall
//           cursor_position scrolled
// config    cfg_index cfg_data                        cfg_write, taken at once
//
// after reset the screen is swept to blank, one cell a cycle, with busy high throughout
// put byte (other than tab) and raw write end in the execute state; raw read adds a read state
// tab: a tab state writes the spaces; set cursor: subtract passes in a wrap state
// clear: a sweep over every cell; each scroll adds a copy sweep, the copy reads one row ahead
// results cannot be held off; done is high for one cycle, busy is low in it

module text_console_writer_top #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tcw_pkg::opcode_t     opcode,
  input  wire logic [7:0]           data_byte,
  input  wire logic [7:0]           column_in,
  input  wire logic [7:0]           row_in,
  input  wire logic                 cfg_write,
  input  wire tcw_pkg::cfg_index_t  cfg_index,
  input  wire logic [3:0]           cfg_data,
  output logic                      done,
  output logic [15:0]               read_entry,
  output logic [6:0]                cursor_column,
  output logic [4:0]                cursor_row,
  output logic [10:0]               cursor_position,
  output logic                      scrolled
);

  import tcw_pkg::*;

  localparam int unsigned CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_TAB    = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_MOD    = 3'd7;

  localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(SCREEN_WIDTH - 1);
  localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(SCREEN_HEIGHT - 1);
  localparam logic [7:0]          W8       = 8'(SCREEN_WIDTH);
  localparam logic [7:0]          H8       = 8'(SCREEN_HEIGHT);

  logic [2:0]          state;
  logic [CNT_W-1:0]    k;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] line;
  logic [3:0]          fg;
  logic [3:0]          bg;
  logic                blink;
  logic [TAB_BITS-1:0] tab_left;

  opcode_t    op_r;
  logic [7:0] ch_r;
  logic [7:0] cx_r;
  logic [7:0] cy_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  cell_t             ram_rdata;

  logic [7:0]        addr_col;
  logic [7:0]        addr_row;
  logic [15:0]       addr_full;
  logic [ADDR_W-1:0] addr_calc;
  logic              in_range;
  logic              raw_op;
  logic              printable;

  logic [COL_BITS-1:0] adv_col;
  logic [ROW_BITS-1:0] adv_line;
  logic                adv_scroll;

  logic [CNT_W-1:0] k_read;
  logic [CNT_W-1:0] k_prev;
  logic [15:0]      pos_full;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared cell address unit: raw access coordinates or the cursor
  assign raw_op    = (op_r == OP_WRITE) || (op_r == OP_READ);
  assign addr_col  = raw_op ? cx_r : 8'(col);
  assign addr_row  = raw_op ? cy_r : 8'(line);
  assign addr_full = {8'b0, addr_row} * 16'(SCREEN_WIDTH) + {8'b0, addr_col};
  assign addr_calc = addr_full[ADDR_W-1:0];
  assign in_range  = (cx_r < W8) && (cy_r < H8);

  assign printable = (ch_r != CH_NL) && (ch_r != CH_TAB) && (ch_r != CH_CR) &&
                     (ch_r != CH_BS);

  always_comb begin
    adv_col    = col + COL_BITS'(1);
    adv_line   = line;
    adv_scroll = 1'b0;
    if (col == COL_LAST) begin
      adv_col = '0;
      if (line == ROW_LAST) begin
        adv_scroll = 1'b1;
      end else begin
        adv_line = line + ROW_BITS'(1);
      end
    end
  end

  assign k_read = k + CNT_W'(SCREEN_WIDTH);
  assign k_prev = k - CNT_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_calc;
    ram_wdata = make_cell(ch_r, fg, bg, blink);
    ram_raddr = addr_calc;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = k[ADDR_W-1:0];
        ram_wdata = CELL_RESET;
      end
      S_EXEC: begin
        if (op_r == OP_PUT) begin
          ram_we = printable;
        end else if (op_r == OP_WRITE) begin
          ram_we = in_range;
        end
      end
      S_TAB: begin
        ram_we    = tab_left != '0;
        ram_wdata = make_cell(CH_SPACE, fg, bg, blink);
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = k[ADDR_W-1:0];
        ram_wdata = make_cell(CH_SPACE, fg, bg, blink);
      end
      S_SCROLL: begin
        // read one row below, write the cell fetched last cycle one row up; blank the bottom row
        ram_raddr = k_read[ADDR_W-1:0];
        ram_we    = k != '0;
        ram_waddr = k_prev[ADDR_W-1:0];
        if (k <= CNT_W'(CELLS - SCREEN_WIDTH)) begin
          ram_wdata = make_cell(ram_rdata[7:0], fg, bg, blink);
        end else begin
          ram_wdata = make_cell(CH_SPACE, fg, bg, blink);
        end
      end
      S_IDLE, S_READ, S_MOD: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state    <= S_INIT;
      k        <= '0;
      col      <= '0;
      line     <= '0;
      fg       <= FG_RESET;
      bg       <= '0;
      blink    <= 1'b0;
      tab_left <= '0;
      scrolled <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FG:    fg    <= cfg_data;
          CFG_BG:    bg    <= cfg_data;
          CFG_BLINK: blink <= cfg_data[0];
          default:   ;
        endcase
      end
      unique case (state)
        S_INIT: begin
          k <= k + CNT_W'(1);
          if (k == CNT_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r       <= opcode;
            ch_r       <= data_byte;
            cx_r       <= column_in;
            cy_r       <= row_in;
            read_entry <= '0;
            scrolled   <= 1'b0;
            tab_left   <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          k     <= '0;
          done  <= 1'b1;
          state <= S_IDLE;
          unique case (op_r)
            OP_PUT: begin
              priority if (ch_r == CH_NL) begin
                col <= '0;
                if (line == ROW_LAST) begin
                  done     <= 1'b0;
                  scrolled <= 1'b1;
                  state    <= S_SCROLL;
                end else begin
                  line <= line + ROW_BITS'(1);
                end
              end else if (ch_r == CH_TAB) begin
                tab_left <= TAB_BITS'(TAB_STOP) - TAB_BITS'(col % COL_BITS'(TAB_STOP));
                done     <= 1'b0;
                state    <= S_TAB;
              end else if (ch_r == CH_CR) begin
                col <= '0;
              end else if (ch_r == CH_BS) begin
                if (col != '0) begin
                  col <= col - COL_BITS'(1);
                end else if (line != '0) begin
                  line <= line - ROW_BITS'(1);
                  col  <= COL_LAST;
                end
              end else begin
                col  <= adv_col;
                line <= adv_line;
                if (adv_scroll) begin
                  done     <= 1'b0;
                  scrolled <= 1'b1;
                  state    <= S_SCROLL;
                end
              end
            end
            OP_READ: begin
              done  <= 1'b0;
              state <= S_READ;
            end
            OP_SET: begin
              done  <= 1'b0;
              state <= S_MOD;
            end
            OP_CLEAR: begin
              done  <= 1'b0;
              state <= S_CLEAR;
            end
            default: ;
          endcase
        end
        S_READ: begin
          read_entry <= in_range ? ram_rdata : '0;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_TAB: begin
          if (tab_left == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            tab_left <= tab_left - TAB_BITS'(1);
            col      <= adv_col;
            line     <= adv_line;
            if (adv_scroll) begin
              k        <= '0;
              scrolled <= 1'b1;
              state    <= S_SCROLL;
            end
          end
        end
        S_SCROLL: begin
          k <= k + CNT_W'(1);
          if (k == CNT_W'(CELLS)) begin
            // a tab cut short by the scroll carries on
            if (tab_left != '0) begin
              state <= S_TAB;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_CLEAR: begin
          k <= k + CNT_W'(1);
          if (k == CNT_W'(CELLS - 1)) begin
            col   <= '0;
            line  <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MOD: begin
          // wrap by repeated subtraction, both coordinates together
          if (cx_r >= W8) begin
            cx_r <= cx_r - W8;
          end
          if (cy_r >= H8) begin
            cy_r <= cy_r - H8;
          end
          if ((cx_r < W8) && (cy_r < H8)) begin
            col   <= cx_r[COL_BITS-1:0];
            line  <= cy_r[ROW_BITS-1:0];
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign busy            = state != S_IDLE;
  assign cursor_column   = col;
  assign cursor_row      = line;
  assign pos_full        = {11'b0, line} * 16'(SCREEN_WIDTH) + {9'b0, col};
  assign cursor_position = pos_full[POS_BITS-1:0];

endmodule

`default_nettype wire

[tb/sv/text_console_writer_checker.sv]
`timescale 1ns / 1ps

module text_console_writer_checker #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  tcw_pkg::opcode_t    opcode,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          column_in,
  input  logic [7:0]          row_in,
  input  logic                cfg_write,
  input  tcw_pkg::cfg_index_t cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                done,
  input  logic [15:0]         read_entry,
  input  logic [6:0]          cursor_column,
  input  logic [4:0]          cursor_row,
  input  logic [10:0]         cursor_position,
  input  logic                scrolled,
  output int                  failures,
  output int                  outstanding,
  output int                  scroll_count
);
  import tcw_pkg::*;

  localparam int unsigned CELLS       = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct {
    logic [15:0] entry;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic        scr;
  } console_report_t;

  cell_t           screen [CELLS];
  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [3:0]      fg;
  logic [3:0]      bg;
  logic            blink;
  logic            scroll_hit;
  int              error_total  = 0;
  int              scroll_total = 0;
  console_report_t pending_reports [$];

  function automatic cell_t paint(logic [7:0] ch);
    // bg and blink overlap on bit 15
    return cell_t'(ch) | (cell_t'(fg) << 8) | (cell_t'(bg) << 12) | (cell_t'(blink) << 15);
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < CELLS; i++) screen[i] = CELL_RESET;
    cur_col = 0;
    cur_row = 0;
    fg      = FG_RESET;
    bg      = '0;
    blink   = 1'b0;
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i + SCREEN_WIDTH < CELLS; i++) begin
      screen[i] = paint(screen[i + SCREEN_WIDTH][7:0]);
    end
    for (int i = CELLS - SCREEN_WIDTH; i < CELLS; i++) screen[i] = paint(CH_SPACE);
    scroll_hit = 1'b1;
  endfunction

  function automatic void next_line();
    cur_row++;
    if (cur_row >= SCREEN_HEIGHT) begin
      cur_row = SCREEN_HEIGHT - 1;
      scroll_up();
    end
  endfunction

  function automatic void emit_char(logic [7:0] ch);
    screen[cur_col + cur_row * SCREEN_WIDTH] = paint(ch);
    cur_col++;
    if (cur_col >= SCREEN_WIDTH) begin
      cur_col = 0;
      next_line();
    end
  endfunction

  function automatic void type_char(logic [7:0] ch);
    int unsigned spaces;
    if (ch == CH_NL) begin
      cur_col = 0;
      next_line();
    end else if (ch == CH_TAB) begin
      spaces = TAB_STOP - (cur_col % TAB_STOP);
      repeat (spaces) emit_char(CH_SPACE);
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_BS) begin
      // backspace does not erase; wraps to the end of the row above
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = SCREEN_WIDTH - 1;
      end
    end else begin
      emit_char(ch);
    end
  endfunction

  function automatic console_report_t run_command(opcode_t op, logic [7:0] ch,
                                                  logic [7:0] cx, logic [7:0] cy);
    console_report_t r;
    logic            on_screen;
    r.entry    = '0;
    scroll_hit = 1'b0;
    on_screen  = (cx < SCREEN_WIDTH) && (cy < SCREEN_HEIGHT);
    case (op)
      OP_PUT: begin
        type_char(ch);
      end
      OP_WRITE: begin
        if (on_screen) screen[int'(cx) + int'(cy) * SCREEN_WIDTH] = paint(ch);
      end
      OP_READ: begin
        if (on_screen) r.entry = screen[int'(cx) + int'(cy) * SCREEN_WIDTH];
      end
      OP_SET: begin
        cur_col = int'(cx) % SCREEN_WIDTH;
        cur_row = int'(cy) % SCREEN_HEIGHT;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = paint(CH_SPACE);
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
      end
    endcase
    r.col = 7'(cur_col);
    r.row = 5'(cur_row);
    r.pos = 11'(cur_col + cur_row * SCREEN_WIDTH);
    r.scr = scroll_hit;
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      error_total++;
      if (error_total <= MAX_REPORTS) begin
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    console_report_t want;
    if (rst) begin
      reset_model();
      pending_reports.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FG:    fg = cfg_data;
          CFG_BG:    bg = cfg_data;
          CFG_BLINK: blink = cfg_data[0];
          default: begin
          end
        endcase
      end
      // result first: a new request can be taken in the same cycle as done
      if (done) begin
        if (scrolled) scroll_total++;
        if (pending_reports.size() == 0) begin
          error_total++;
          if (error_total <= MAX_REPORTS) begin
            $display("%0t: result with none expected, read_entry %0h cursor %0d,%0d",
                     $time, read_entry, cursor_column, cursor_row);
          end
        end else begin
          want = pending_reports.pop_front();
          check_field("read_entry", want.entry, read_entry);
          check_field("cursor_column", want.col, cursor_column);
          check_field("cursor_row", want.row, cursor_row);
          check_field("cursor_position", want.pos, cursor_position);
          check_field("scrolled", want.scr, scrolled);
        end
      end
      if (start && !busy) begin
        pending_reports.push_back(run_command(opcode, data_byte, column_in, row_in));
      end
    end
    failures     <= error_total;
    outstanding  <= pending_reports.size();
    scroll_count <= scroll_total;
  end

endmodule

[tb/sv/tb_text_console_writer_top.sv]
`timescale 1ns / 1ps

module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int unsigned SCREEN_WIDTH  = 80;
  localparam int unsigned SCREEN_HEIGHT = 25;
  localparam int unsigned CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 215;
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;
  localparam int unsigned DRAIN_CYCLES  = CELLS + 64;
  localparam opcode_t     OP_LAST       = '1;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  opcode_t             opcode;
  logic [7:0]          data_byte;
  logic [7:0]          column_in;
  logic [7:0]          row_in;
  logic                cfg_write;
  cfg_index_t          cfg_index;
  logic [3:0]          cfg_data;
  logic                done;
  logic [15:0]         read_entry;
  logic [6:0]          cursor_column;
  logic [4:0]          cursor_row;
  logic [10:0]         cursor_position;
  logic                scrolled;

  int                  failures;
  int                  outstanding;
  int                  scroll_count;
  int unsigned         cycles = 0;
  int unsigned         sent_by_op [8];
  int unsigned         settings_used = 0;
  logic                steady = 1'b0;
  logic [7:0]          hot_col = '0;
  logic [7:0]          hot_row = '0;

  text_console_writer_top #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .column_in      (column_in),
    .row_in         (row_in),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .read_entry     (read_entry),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .cursor_position(cursor_position),
    .scrolled       (scrolled)
  );

  text_console_writer_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .column_in      (column_in),
    .row_in         (row_in),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .read_entry     (read_entry),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .cursor_position(cursor_position),
    .scrolled       (scrolled),
    .failures       (failures),
    .outstanding    (outstanding),
    .scroll_count   (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // start stays high when the next request follows at once
  task automatic issue(opcode_t op, logic [7:0] ch, logic [7:0] cx, logic [7:0] cy);
    int unsigned gap;
    opcode    <= op;
    data_byte <= ch;
    column_in <= cx;
    row_in    <= cy;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    sent_by_op[op]++;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_colours(logic [3:0] fg, logic [3:0] bg, logic blink);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    // upper bits of the blink write are junk and must be dropped
    cfg_index <= CFG_BLINK;
    cfg_data  <= {3'($urandom), blink};
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_coord(int unsigned span);
    if ($urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(CH_SPACE, 8'h7E));
    if (pick < 78) return CH_NL;
    if (pick < 83) return CH_TAB;
    if (pick < 87) return CH_CR;
    if (pick < 92) return CH_BS;
    return 8'($urandom);
  endfunction

  task automatic random_command();
    int unsigned pick;
    logic [7:0]  cx;
    logic [7:0]  cy;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      issue(OP_PUT, pick_char(), 8'($urandom), 8'($urandom));
    end else if (pick < 67) begin
      cx = pick_coord(SCREEN_WIDTH);
      cy = pick_coord(SCREEN_HEIGHT);
      if (cx < SCREEN_WIDTH && cy < SCREEN_HEIGHT) begin
        hot_col = cx;
        hot_row = cy;
      end
      issue(OP_WRITE, 8'($urandom), cx, cy);
    end else if (pick < 82) begin
      // read near recent writes or the cursor so typed text gets looked at
      if ($urandom_range(0, 2) == 0) begin
        cx = hot_col + 8'($urandom_range(0, 7));
        cy = hot_row;
      end else begin
        cx = pick_coord(SCREEN_WIDTH);
        cy = pick_coord(SCREEN_HEIGHT);
      end
      issue(OP_READ, 8'($urandom), cx, cy);
    end else if (pick < 92) begin
      if ($urandom_range(0, 3) == 0) begin
        // park near the end of the bottom row so text soon scrolls
        cx = 8'($urandom_range(SCREEN_WIDTH - 6, SCREEN_WIDTH - 1));
        cy = 8'(SCREEN_HEIGHT - 1);
      end else begin
        cx = 8'($urandom);
        cy = 8'($urandom);
      end
      hot_col = 8'(int'(cx) % SCREEN_WIDTH);
      hot_row = 8'(int'(cy) % SCREEN_HEIGHT);
      issue(OP_SET, 8'($urandom), cx, cy);
    end else if (pick < 95) begin
      issue(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      issue(opcode_t'($urandom_range(OP_CLEAR + 1, OP_LAST)), 8'($urandom), 8'($urandom),
            8'($urandom));
    end
  endtask

  task automatic directed_commands();
    logic [7:0] last_col;
    logic [7:0] last_row;
    last_col = 8'(SCREEN_WIDTH - 1);
    last_row = 8'(SCREEN_HEIGHT - 1);
    issue(OP_READ, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 8'h00, 8'(SCREEN_WIDTH), 8'h00);
    issue(OP_READ, 8'h00, 8'hFF, 8'hFF);
    issue(OP_WRITE, 8'hFF, last_col, last_row);
    issue(OP_WRITE, 8'h41, 8'(SCREEN_WIDTH), 8'h03);
    issue(OP_WRITE, 8'h42, 8'h00, 8'(SCREEN_HEIGHT));
    issue(OP_READ, 8'h00, last_col, last_row);
    issue(OP_PUT, 8'h41, 8'h00, 8'h00);
    issue(OP_PUT, 8'h00, 8'h00, 8'h00);
    issue(OP_PUT, 8'hFF, 8'h00, 8'h00);
    issue(OP_PUT, CH_TAB, 8'h00, 8'h00);
    issue(OP_READ, 8'h00, 8'h02, 8'h00);
    issue(OP_PUT, CH_CR, 8'h00, 8'h00);
    // backspace at the home position stays put
    issue(OP_PUT, CH_BS, 8'h00, 8'h00);
    issue(OP_SET, 8'h00, 8'h00, 8'h01);
    issue(OP_PUT, CH_BS, 8'h00, 8'h00);
    issue(OP_SET, 8'h00, 8'hFF, 8'hFF);
    issue(OP_SET, 8'h00, last_col, last_row);
    issue(OP_PUT, 8'h78, 8'h00, 8'h00);
    issue(OP_SET, 8'h00, 8'(SCREEN_WIDTH - 2), last_row);
    issue(OP_PUT, CH_TAB, 8'h00, 8'h00);
    issue(OP_PUT, CH_NL, 8'h00, 8'h00);
    issue(OP_READ, 8'h00, last_col, 8'(SCREEN_HEIGHT - 4));
    issue(OP_CLEAR, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 8'h00, 8'h05, 8'h05);
    issue(opcode_t'(OP_CLEAR + 1), 8'h00, 8'h00, 8'h00);
    issue(OP_LAST, 8'hFF, 8'hFF, 8'hFF);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    opcode    = OP_PUT;
    data_byte = '0;
    column_in = '0;
    row_in    = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_FG;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // let the blanking sweep after reset finish
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);

    set_colours(FG_RESET, 4'h0, 1'b0);
    directed_commands();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_colours(4'h0, 4'h0, 1'b0);
        1: set_colours(4'hF, 4'hF, 1'b1);
        2: set_colours(4'($urandom), 4'($urandom), 1'($urandom));
        3: set_colours(4'hF, 4'h0, 1'b1);
        default: set_colours(4'h0, 4'hF, 1'b0);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        random_command();
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("requests: %0d put, %0d raw write, %0d raw read, %0d cursor set, %0d clear",
             sent_by_op[OP_PUT], sent_by_op[OP_WRITE], sent_by_op[OP_READ],
             sent_by_op[OP_SET], sent_by_op[OP_CLEAR]);
    $display("%0d unused codes, %0d colour settings, %0d scrolling results, %0d cycles",
             sent_by_op[5] + sent_by_op[6] + sent_by_op[7], settings_used, scroll_count,
             cycles);
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer_top.sv
tb/sv/text_console_writer_checker.sv
tb/sv/tb_text_console_writer_top.sv
